/* src/scja_pkg.sv */
// Package for the seeded cone jet accumulator: field widths, reset values,
// register indexes, the divider status struct and the moment saturation helper.
// No dependencies.
package scja_pkg;

	localparam int PtW      = 16;
	localparam int EnergyW  = 20;
	localparam int EtaW     = 13;
	localparam int PhiW     = 12;
	localparam int RadiusW  = 12;
	localparam int CountW   = 11;
	localparam int EsumW    = 30;
	localparam int PsumW    = 26;
	localparam int MomW     = 48;
	localparam int MulW     = 17;
	localparam int ProdW    = 2 * MulW;
	localparam int DistW    = 28;
	localparam int InDataW  = 64;
	localparam int OutDataW = 112;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	localparam int MaxParticlesDef = 1024;

	localparam logic [RadiusW-1:0] ConeRadiusRst  = 12'd196;
	localparam logic [PtW-1:0]     PtThresholdRst = 16'd200;
	localparam logic [RadiusW-1:0] EtaLimitRst    = 12'd652;

	localparam logic [CfgIdxW-1:0] RegConeRadius  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegPtThreshold = 2'd1;
	localparam logic [CfgIdxW-1:0] RegEtaLimit    = 2'd2;

	localparam logic [MomW-1:0] MomMax = {1'b0, {(MomW-1){1'b1}}};
	localparam logic [MomW-1:0] MomMin = {1'b1, {(MomW-1){1'b0}}};

	typedef struct packed {
		logic busy;
		logic done;
	} scja_div_stat_t;

	function automatic logic [MomW-1:0] mom_sat(input logic [MomW:0] s);
		logic [MomW-1:0] r;
		if (s[MomW] != s[MomW-1]) begin
			r = s[MomW] ? MomMin : MomMax;
		end else begin
			r = s[MomW-1:0];
		end
		return r;
	endfunction

	function automatic logic [MomW-1:0] mom_abs(input logic [MomW-1:0] v);
		return v[MomW-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

/* src/scja_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on scja_pkg for the operand and product widths.
module scja_mul import scja_pkg::*; (
	input  logic                    clk,
	input  logic signed [MulW-1:0]  a,
	input  logic signed [MulW-1:0]  b,
	output logic signed [ProdW-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

/* src/scja_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on scja_pkg for widths and the status struct.
module scja_div import scja_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MomW-1:0]  dividend,
	input  logic [PsumW-1:0] divisor,
	output scja_div_stat_t   stat,
	output logic [MomW-1:0]  quotient
);

	localparam int CntW = $clog2(MomW);

	logic [PsumW-1:0] rem_q;
	logic [PsumW-1:0] dvs_q;
	logic [MomW-1:0]  quo_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PsumW:0]   trial;
	logic [PsumW:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[MomW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
				cnt_q  <= CntW'(MomW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[PsumW-1:0] : trial[PsumW-1:0];
				quo_q <= {quo_q[MomW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

/* src/seeded_cone_jet_accumulator_top.sv */
// Seeded cone jet accumulator: a seed beat sets the jet axis and clears the sums; candidate
// beats inside the cone are accumulated. A seed beat or a candidate beat rejected by the eta or
// pt cut returns straight to idle unless it is marked last. A candidate that reaches the cone test
// steps through the distance states and the compare, and through two moment states more when it
// lies inside the cone, because one shared multiplier forms the squared distances, the squared
// radius and the two moment products in turn. A beat marked last folds the seed into the sums and
// runs the one-bit-per-cycle divider twice, for the phi and eta axes; with a zero pt sum the
// divider is skipped and the seed axis is output. The result waits while the previous one is
// still held by a low m_tready. s_tready is low meanwhile. Depends on scja_pkg, scja_mul and scja_div.
module seeded_cone_jet_accumulator_top import scja_pkg::*; #(
	parameter int MAX_PARTICLES = MaxParticlesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // pt, energy, eta, phi
	input  logic [0:0]          s_tuser,  // mode
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // particle_count, energy_sum, pt_sum, jet phi,
	                                      // jet eta, seed_pt
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int CountCapInt = (MAX_PARTICLES < 2047) ? MAX_PARTICLES : 2046;
	localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DETA, ST_DPHI, ST_RAD, ST_CMP, ST_PMOM, ST_EMOM,
		ST_RSEED, ST_RSUM, ST_DIVP, ST_WAITP, ST_DIVE, ST_WAITE, ST_OUT
	} state_t;

	state_t state_q;

	logic [RadiusW-1:0] cone_radius_q;
	logic [PtW-1:0]     pt_threshold_q;
	logic [RadiusW-1:0] eta_limit_q;

	logic [PhiW-1:0]    seed_phi_q;
	logic [EtaW-1:0]    seed_eta_q;
	logic [PtW-1:0]     seed_pt_q;
	logic [EnergyW-1:0] seed_energy_q;
	logic [CountW-1:0]  count_q;
	logic [EsumW-1:0]   energy_acc_q;
	logic [PsumW-1:0]   pt_acc_q;
	logic [MomW-1:0]    phi_mom_q;
	logic [MomW-1:0]    eta_mom_q;

	logic               last_q;
	logic [PtW-1:0]     pt_q;
	logic [EnergyW-1:0] energy_q;
	logic [EtaW-1:0]    eta_q;
	logic [PhiW-1:0]    phi_q;
	logic [DistW-1:0]   dist_q;

	logic [EsumW-1:0]   esum_q;
	logic [PsumW-1:0]   psum_q;
	logic [MomW-1:0]    emom_q;
	logic [PhiW-1:0]    aphi_q;
	logic [EtaW-1:0]    aeta_q;

	logic                m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;

	logic               in_mode;
	logic [PtW-1:0]     in_pt;
	logic [EnergyW-1:0] in_energy;
	logic [EtaW-1:0]    in_eta;
	logic [PhiW-1:0]    in_phi;
	logic [EtaW-1:0]    in_aeta;
	logic               in_pass;
	logic               in_acc;

	logic [EtaW:0]      deta;
	logic [PhiW-1:0]    dphi;
	logic signed [MulW-1:0]  mul_a;
	logic signed [MulW-1:0]  mul_b;
	logic signed [ProdW-1:0] prod_s1;
	logic               in_cone;

	logic [EsumW:0]     esum_next;
	logic [PsumW:0]     psum_next;
	logic [EsumW:0]     esum_res;
	logic [PsumW:0]     psum_res;
	logic [MomW:0]      pmom_sum;
	logic [MomW:0]      emom_sum;
	logic [MomW:0]      emom_res;

	logic               div_start;
	logic [MomW-1:0]    div_dividend;
	scja_div_stat_t     div_stat;
	logic [MomW-1:0]    div_quo;
	logic [PhiW-1:0]    q_phi;
	logic [EtaW-1:0]    q_eta;

	assign in_mode   = s_tuser[0];
	assign in_pt     = s_tdata[15:0];
	assign in_energy = s_tdata[35:16];
	assign in_eta    = s_tdata[48:36];
	assign in_phi    = s_tdata[60:49];
	assign in_aeta   = in_eta[EtaW-1] ? (~in_eta + 1'b1) : in_eta;
	assign in_pass   = (in_aeta < {1'b0, eta_limit_q}) && (in_pt >= pt_threshold_q);
	assign in_acc    = s_tvalid && s_tready;

	assign s_tready = (state_q == ST_IDLE);

	assign deta = {eta_q[EtaW-1], eta_q} - {seed_eta_q[EtaW-1], seed_eta_q};
	assign dphi = phi_q - seed_phi_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DETA: begin
				mul_a = {{(MulW-EtaW-1){deta[EtaW]}}, deta};
				mul_b = {{(MulW-EtaW-1){deta[EtaW]}}, deta};
			end
			ST_DPHI: begin
				mul_a = {{(MulW-PhiW){dphi[PhiW-1]}}, dphi};
				mul_b = {{(MulW-PhiW){dphi[PhiW-1]}}, dphi};
			end
			ST_RAD: begin
				mul_a = {{(MulW-RadiusW){1'b0}}, cone_radius_q};
				mul_b = {{(MulW-RadiusW){1'b0}}, cone_radius_q};
			end
			ST_CMP: begin
				mul_a = {{(MulW-PhiW){dphi[PhiW-1]}}, dphi};
				mul_b = {1'b0, pt_q};
			end
			ST_PMOM: begin
				mul_a = {{(MulW-EtaW){eta_q[EtaW-1]}}, eta_q};
				mul_b = {1'b0, pt_q};
			end
			ST_RSEED: begin
				mul_a = {{(MulW-EtaW){seed_eta_q[EtaW-1]}}, seed_eta_q};
				mul_b = {1'b0, seed_pt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	scja_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	assign in_cone   = dist_q < prod_s1[DistW-1:0];
	assign esum_next = {1'b0, energy_acc_q} + {{(EsumW-EnergyW+1){1'b0}}, energy_q};
	assign psum_next = {1'b0, pt_acc_q} + {{(PsumW-PtW+1){1'b0}}, pt_q};
	assign esum_res  = {1'b0, energy_acc_q} + {{(EsumW-EnergyW+1){1'b0}}, seed_energy_q};
	assign psum_res  = {1'b0, pt_acc_q} + {{(PsumW-PtW+1){1'b0}}, seed_pt_q};
	assign pmom_sum  = {phi_mom_q[MomW-1], phi_mom_q}
	                 - {{(MomW+1-ProdW){prod_s1[ProdW-1]}}, prod_s1};
	assign emom_sum  = {eta_mom_q[MomW-1], eta_mom_q}
	                 + {{(MomW+1-ProdW){prod_s1[ProdW-1]}}, prod_s1};
	assign emom_res  = emom_sum;

	assign div_start    = (state_q == ST_DIVP && psum_q != '0) || (state_q == ST_DIVE);
	assign div_dividend = (state_q == ST_DIVP) ? mom_abs(phi_mom_q) : mom_abs(emom_q);

	scja_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (psum_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign q_phi = phi_mom_q[MomW-1] ? (~div_quo[PhiW-1:0] + 1'b1) : div_quo[PhiW-1:0];

	always_comb begin
		if (emom_q[MomW-1]) begin
			q_eta = (div_quo > MomW'(4096)) ? 13'h1000 : (~div_quo[EtaW-1:0] + 1'b1);
		end else begin
			q_eta = (div_quo > MomW'(4095)) ? 13'h0FFF : div_quo[EtaW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cone_radius_q  <= ConeRadiusRst;
			pt_threshold_q <= PtThresholdRst;
			eta_limit_q    <= EtaLimitRst;
			seed_phi_q     <= '0;
			seed_eta_q     <= '0;
			seed_pt_q      <= '0;
			seed_energy_q  <= '0;
			count_q        <= '0;
			energy_acc_q   <= '0;
			pt_acc_q       <= '0;
			phi_mom_q      <= '0;
			eta_mom_q      <= '0;
			last_q         <= 1'b0;
			pt_q           <= '0;
			energy_q       <= '0;
			eta_q          <= '0;
			phi_q          <= '0;
			dist_q         <= '0;
			esum_q         <= '0;
			psum_q         <= '0;
			emom_q         <= '0;
			aphi_q         <= '0;
			aeta_q         <= '0;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegConeRadius:  cone_radius_q  <= cfg_data[RadiusW-1:0];
					RegPtThreshold: pt_threshold_q <= cfg_data[PtW-1:0];
					RegEtaLimit:    eta_limit_q    <= cfg_data[RadiusW-1:0];
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q   <= s_tlast;
						pt_q     <= in_pt;
						energy_q <= in_energy;
						eta_q    <= in_eta;
						phi_q    <= in_phi;
						if (!in_mode) begin
							seed_phi_q    <= in_phi;
							seed_eta_q    <= in_eta;
							seed_pt_q     <= in_pt;
							seed_energy_q <= in_energy;
							count_q       <= '0;
							energy_acc_q  <= '0;
							pt_acc_q      <= '0;
							phi_mom_q     <= '0;
							eta_mom_q     <= '0;
							state_q       <= s_tlast ? ST_RSEED : ST_IDLE;
						end else if (in_pass) begin
							state_q <= ST_DETA;
						end else begin
							state_q <= s_tlast ? ST_RSEED : ST_IDLE;
						end
					end
				end
				ST_DETA: state_q <= ST_DPHI;
				ST_DPHI: begin
					dist_q  <= prod_s1[DistW-1:0];
					state_q <= ST_RAD;
				end
				ST_RAD: begin
					dist_q  <= dist_q + prod_s1[DistW-1:0];
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (in_cone) begin
						if (count_q < CountCap) begin
							count_q <= count_q + 1'b1;
						end
						energy_acc_q <= esum_next[EsumW] ? '1 : esum_next[EsumW-1:0];
						pt_acc_q     <= psum_next[PsumW] ? '1 : psum_next[PsumW-1:0];
						state_q      <= ST_PMOM;
					end else begin
						state_q <= last_q ? ST_RSEED : ST_IDLE;
					end
				end
				ST_PMOM: begin
					phi_mom_q <= mom_sat(pmom_sum);
					state_q   <= ST_EMOM;
				end
				ST_EMOM: begin
					eta_mom_q <= mom_sat(emom_sum);
					state_q   <= last_q ? ST_RSEED : ST_IDLE;
				end
				ST_RSEED: state_q <= ST_RSUM;
				ST_RSUM: begin
					esum_q  <= esum_res[EsumW] ? '1 : esum_res[EsumW-1:0];
					psum_q  <= psum_res[PsumW] ? '1 : psum_res[PsumW-1:0];
					emom_q  <= mom_sat(emom_res);
					state_q <= ST_DIVP;
				end
				ST_DIVP: begin
					if (psum_q == '0) begin
						aphi_q  <= seed_phi_q;
						aeta_q  <= seed_eta_q;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_WAITP;
					end
				end
				ST_WAITP: begin
					if (div_stat.done) begin
						aphi_q  <= seed_phi_q - q_phi;
						state_q <= ST_DIVE;
					end
				end
				ST_DIVE: state_q <= ST_WAITE;
				ST_WAITE: begin
					if (div_stat.done) begin
						aeta_q  <= q_eta;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, seed_pt_q, aeta_q, aphi_q, psum_q, esum_q,
						               count_q + 1'b1};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountCap)
		else $error("candidate count exceeds its cap");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_seed_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_mode) |=> (count_q == '0 && pt_acc_q == '0 && energy_acc_q == '0))
		else $error("seed beat did not clear the accumulators");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAITP || state_q == ST_WAITE) |-> psum_q != '0)
		else $error("division by a zero pt sum");
`endif

endmodule

/* bench/tb_seeded_cone_jet_accumulator_top.sv */
// Self-checking bench for seeded_cone_jet_accumulator_top: streams seed and candidate beats,
// predicts each jet result in step with the accepted beats and checks every output field.
// Depends on scja_pkg and the accumulator RTL.
module tb_seeded_cone_jet_accumulator_top;
	import scja_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit ModeSeed = 1'b0;
	localparam bit ModeCand = 1'b1;
	localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
	localparam longint EsumMax = (64'sd1 << EsumW) - 1;
	localparam longint PsumMax = (64'sd1 << PsumW) - 1;
	localparam longint MomHi = 64'sh7FFF_FFFF_FFFF;
	localparam longint MomLo = -MomHi - 1;
	localparam int WatchdogLimit = 3000;

	typedef struct {
		bit                      mode;
		bit                      last;
		logic [PtW-1:0]          pt;
		logic [EnergyW-1:0]      energy;
		logic signed [EtaW-1:0]  eta;
		logic signed [PhiW-1:0]  phi;
	} beat_t;

	typedef struct {
		logic [CountW-1:0]       count;
		logic [EsumW-1:0]        esum;
		logic [PsumW-1:0]        psum;
		logic signed [PhiW-1:0]  aphi;
		logic signed [EtaW-1:0]  aeta;
		logic [PtW-1:0]          seed_pt;
	} jet_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InDataW-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	beat_t beat_q[$];
	jet_t jet_q[$];
	beat_t cur_beat;
	jet_t pred_jet;
	jet_t want_jet;

	longint radius_q, pt_thr_q, eta_lim_q;
	longint seed_phi_q, seed_eta_q, seed_pt_q, seed_en_q;
	longint n_clustered, en_total, pt_total, phi_mom, eta_mom;

	int errors = 0;
	int beats_in = 0;
	int jets_out = 0;
	int settings_seen = 0;
	int queued = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	int quiet = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	seeded_cone_jet_accumulator_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint mom_clamp(longint v);
		if (v > MomHi) return MomHi;
		if (v < MomLo) return MomLo;
		return v;
	endfunction

	function automatic longint usat(longint v, longint hi);
		return (v > hi) ? hi : v;
	endfunction

	function automatic bit cluster_beat(input beat_t b, output jet_t r);
		longint pt, en, eta, phi, deta, dphi, rad, q, emom, psum, ax_eta;
		logic signed [PhiW-1:0] wrapped;
		pt = b.pt;
		en = b.energy;
		eta = b.eta;
		phi = b.phi;
		r = '{default: '0};
		if (b.mode == ModeSeed) begin
			seed_phi_q = phi;
			seed_eta_q = eta;
			seed_pt_q = pt;
			seed_en_q = en;
			n_clustered = 0;
			en_total = 0;
			pt_total = 0;
			phi_mom = 0;
			eta_mom = 0;
		end else if (((eta < 0) ? -eta : eta) < eta_lim_q && pt >= pt_thr_q) begin
			deta = eta - seed_eta_q;
			wrapped = PhiW'(phi - seed_phi_q);
			dphi = wrapped;
			rad = radius_q;
			if (deta * deta + dphi * dphi < rad * rad) begin
				if (n_clustered < MaxParticlesDef) n_clustered++;
				en_total = usat(en_total + en, EsumMax);
				pt_total = usat(pt_total + pt, PsumMax);
				phi_mom = mom_clamp(phi_mom - dphi * pt);
				eta_mom = mom_clamp(eta_mom + eta * pt);
			end
		end
		if (!b.last) return 1'b0;
		psum = usat(pt_total + seed_pt_q, PsumMax);
		emom = mom_clamp(eta_mom + seed_eta_q * seed_pt_q);
		r.count = CountW'(n_clustered + 1);
		r.esum = EsumW'(usat(en_total + seed_en_q, EsumMax));
		r.psum = PsumW'(psum);
		r.seed_pt = PtW'(seed_pt_q);
		r.aphi = PhiW'(seed_phi_q);
		r.aeta = EtaW'(seed_eta_q);
		if (psum != 0) begin
			q = phi_mom / psum;
			wrapped = PhiW'(seed_phi_q - q);
			r.aphi = wrapped;
			ax_eta = emom / psum;
			if (ax_eta > 4095) ax_eta = 4095;
			if (ax_eta < -4096) ax_eta = -4096;
			r.aeta = EtaW'(ax_eta);
		end
		return 1'b1;
	endfunction

	function automatic void check_field(string fname, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", fname, want, got);
			errors++;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				beats_in++;
				if (cluster_beat(cur_beat, pred_jet)) jet_q.insert(jet_q.size(), pred_jet);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (beat_q.size() != 0) begin
					cur_beat = beat_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, cur_beat.phi, cur_beat.eta, cur_beat.energy, cur_beat.pt};
					s_tuser <= cur_beat.mode;
					s_tlast <= cur_beat.last;
					tx_gap = tx_calm ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				jets_out++;
				if (jet_q.size() == 0) begin
					$error("jet result with no expectation waiting");
					errors++;
				end else begin
					want_jet = jet_q.pop_front();
					check_field("particle_count", want_jet.count, m_tdata[10:0]);
					check_field("energy_sum", want_jet.esum, m_tdata[40:11]);
					check_field("pt_sum", want_jet.psum, m_tdata[66:41]);
					check_field("jet_phi", want_jet.aphi, $signed(m_tdata[78:67]));
					check_field("jet_eta", want_jet.aeta, $signed(m_tdata[91:79]));
					check_field("seed_pt", want_jet.seed_pt, m_tdata[107:92]);
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 99) < 20) rx_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet == WatchdogLimit) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic push_beat(bit mode, bit last, int pt, int energy, int eta, int phi);
		beat_t b;
		b.mode = mode;
		b.last = last;
		b.pt = pt[PtW-1:0];
		b.energy = energy[EnergyW-1:0];
		b.eta = eta[EtaW-1:0];
		b.phi = phi[PhiW-1:0];
		beat_q.insert(beat_q.size(), b);
		queued++;
	endtask

	task automatic cfg_write(logic [CfgIdxW-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CfgDataW-1:0];
		case (idx)
			RegConeRadius: radius_q = longint'(val & 'hFFF);
			RegPtThreshold: pt_thr_q = longint'(val & 'hFFFF);
			RegEtaLimit: eta_lim_q = longint'(val & 'hFFF);
			default: ;
		endcase
	endtask

	task automatic set_cuts(int radius, int thr, int lim);
		cfg_write(RegConeRadius, radius);
		cfg_write(RegPtThreshold, thr);
		cfg_write(RegEtaLimit, lim);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_seen++;
	endtask

	task automatic wait_idle();
		while (beat_q.size() != 0 || s_tvalid || jet_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
	endtask

	function automatic int pick_cut(int hi, int tlo, int thi);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return hi;
			default: return $urandom_range(tlo, thi);
		endcase
	endfunction

	task automatic push_random_jet();
		int s_eta, s_phi, n, spread, c_eta, c_phi, c_pt;
		bit fin;
		if ($urandom_range(0, 9) == 0) s_eta = int'($urandom_range(0, 8191)) - 4096;
		else s_eta = int'($urandom_range(0, 1400)) - 700;
		s_phi = int'($urandom_range(0, 4095)) - 2048;
		n = $urandom_range(0, 14);
		spread = int'(radius_q) + 40;
		push_beat(ModeSeed, n == 0, $urandom_range(0, 65535), $urandom_range(0, 1048575),
			s_eta, s_phi);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				c_eta = s_eta + int'($urandom_range(0, 2 * spread)) - spread;
				c_phi = s_phi + int'($urandom_range(0, 2 * spread)) - spread;
			end else begin
				c_eta = int'($urandom_range(0, 8191)) - 4096;
				c_phi = int'($urandom_range(0, 4095)) - 2048;
			end
			case ($urandom_range(0, 3))
				0: c_pt = $urandom_range(0, 65535);
				1: c_pt = int'(pt_thr_q) + int'($urandom_range(0, 2)) - 1;
				default: c_pt = $urandom_range(0, 3000);
			endcase
			if (c_pt < 0) c_pt = 0;
			if (c_pt > 65535) c_pt = 65535;
			fin = (i == n - 1) && ($urandom_range(0, 9) != 0);
			push_beat(ModeCand, fin, c_pt, $urandom_range(0, 1048575), c_eta, c_phi);
		end
	endtask

	task automatic push_random_phase(int target);
		int stop;
		stop = queued + target;
		while (queued < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				push_beat($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 65535),
					$urandom_range(0, 1048575), int'($urandom_range(0, 8191)) - 4096,
					int'($urandom_range(0, 4095)) - 2048);
			end else begin
				push_random_jet();
			end
		end
		if (beat_q.size() != 0) beat_q[$].last = 1'b1;
	endtask

	initial begin
		radius_q = ConeRadiusRst;
		pt_thr_q = PtThresholdRst;
		eta_lim_q = EtaLimitRst;
		seed_phi_q = 0;
		seed_eta_q = 0;
		seed_pt_q = 0;
		seed_en_q = 0;
		n_clustered = 0;
		en_total = 0;
		pt_total = 0;
		phi_mom = 0;
		eta_mom = 0;
		settings_seen = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_beat(ModeCand, 0, 300, 1000, 10, -5);
		push_beat(ModeCand, 1, 65535, 1048575, 651, 100);
		push_beat(ModeSeed, 1, 0, 77, 123, -77);
		push_beat(ModeSeed, 0, 65535, 1048575, -500, -2048);
		push_beat(ModeCand, 0, 200, 0, -651, 2040);
		push_beat(ModeCand, 0, 199, 500, -500, -2048);
		push_beat(ModeCand, 0, 5000, 500, -652, -2048);
		push_beat(ModeCand, 0, 1000, 500, -304, -2048);
		push_beat(ModeCand, 1, 1000, 500, -305, -2048);
		push_beat(ModeCand, 1, 400, 9, -500, -2048);
		push_beat(ModeSeed, 0, 1, 0, 4095, 2047);
		push_beat(ModeCand, 1, 65535, 3, 600, 2047);
		push_beat(ModeSeed, 1, 65535, 0, -4096, 0);
		push_beat(ModeSeed, 0, 0, 0, 0, 0);
		push_beat(ModeCand, 1, 0, 5, 0, 0);
		wait_idle();

		set_cuts(4095, 0, 4095);
		push_beat(ModeSeed, 0, 65535, 1048575, 0, 0);
		for (int i = 0; i < 1030; i++) begin
			push_beat(ModeCand, i == 1029, 65535, 1048575, int'($urandom_range(0, 400)) - 200,
				int'($urandom_range(0, 4095)) - 2048);
		end
		wait_idle();

		cfg_write(RegSpare, $urandom_range(0, 65535));
		set_cuts(0, 65535, 0);
		push_random_phase(60);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			set_cuts(pick_cut(4095, 40, 600), pick_cut(65535, 0, 3000), pick_cut(4095, 200, 2000));
			push_random_phase(90);
			wait_idle();
		end

		repeat (30) @(posedge clk);
		$display("Covered %0d beats and %0d jet results over %0d cut settings,", beats_in,
			jets_out, settings_seen);
		$display("with saturated sums, wrapped azimuths, seedless candidates and stalls.");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

/* files.f */
src/scja_pkg.sv
src/scja_mul.sv
src/scja_div.sv
src/seeded_cone_jet_accumulator_top.sv
bench/tb_seeded_cone_jet_accumulator_top.sv
